// File: rtl/assert_macros.svh
// Assertion macros shared by the keypad scanner and code lock RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

// File: rtl/kscl_pkg.sv
// Types, constants and helper functions for the keypad scanner and code lock.
package kscl_pkg;

	// Key matrix geometry.
	localparam int unsigned KEY_COLS = 4;
	localparam int unsigned ROW_W    = 2;

	// Reset values of the configuration registers.
	localparam logic [15:0] INTERVAL_RESET = 16'd100;
	localparam logic [43:0] PASSCODE_RESET = 44'd1305675318054;

	// Register indexes, taken from paddr bit 3 (registers sit 8 bytes apart).
	localparam logic REG_SCAN_INTERVAL = 1'b0;
	localparam logic REG_PASSCODE      = 1'b1;

	// Key codes of the special keys and the mask of the digit keys.
	localparam logic [15:0] KEY_CLEAR  = 16'd8;
	localparam logic [15:0] KEY_BACK   = 16'd128;
	localparam logic [15:0] KEY_ENTER  = 16'd32768;
	localparam logic [15:0] DIGIT_KEYS = 16'h1777;

	// Digit entered by each key bit.
	localparam logic [3:0] KEY_DIGIT [16] = '{
		4'd7, 4'd8, 4'd9, 4'd0, 4'd4, 4'd5, 4'd6, 4'd0,
		4'd1, 4'd2, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
	};

	// Depth of the queue between the scanner and the lock.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Action that a key press asks of the lock.
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_DIGIT,
		ACT_CLEAR,
		ACT_BACK,
		ACT_ENTER
	} key_action_t;

	// One classified tick handed from the scanner to the lock.
	typedef struct packed {
		logic [3:0]  row_drive;
		logic [15:0] key_word;
		key_action_t action;
		logic [3:0]  digit;
	} front_item_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Digit of a single pressed key (key word is one-hot).
	function automatic logic [3:0] key_to_digit(input logic [15:0] key_map);
		logic [3:0] d;
		d = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (key_map[i]) begin
				d = d | KEY_DIGIT[i];
			end
		end
		return d;
	endfunction

endpackage

// File: rtl/kscl_front.sv
// Scanner front: tick counter, row scan, key map and key classification.
`include "assert_macros.svh"

module kscl_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [3:0]             column_levels,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [15:0]            scan_interval,
	input  kscl_pkg::queue_status_t q_status,
	output logic                   push_valid,
	output kscl_pkg::front_item_t  push_item
);
	import kscl_pkg::*;

	logic [15:0]      elapsed_q;
	logic [ROW_W-1:0] scan_row_q;
	logic [3:0]       row_levels_q;
	logic [15:0]      pressed_q;
	logic [15:0]      previous_q;

	logic [15:0]      elapsed_inc;
	logic             scan_now;
	logic [15:0]      elapsed_next;
	logic [ROW_W-1:0] scan_row_next;
	logic [3:0]       row_levels_next;
	logic [15:0]      pressed_next;
	logic             press_edge;
	key_action_t      action;

	// Stall only while the queue has no room.
	assign in_stall   = q_status.full;
	assign push_valid = in_valid && !q_status.full;

	// Tick counter and row scan for the accepted tick.
	always_comb begin
		elapsed_inc     = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
		scan_now        = (elapsed_inc >= scan_interval);
		elapsed_next    = scan_now ? 16'd0 : elapsed_inc;
		pressed_next    = pressed_q;
		scan_row_next   = scan_row_q;
		row_levels_next = row_levels_q;
		if (scan_now) begin
			for (int c = 0; c < KEY_COLS; c++) begin
				pressed_next[{scan_row_q, ROW_W'(c)}] = ~column_levels[c];
			end
			scan_row_next   = scan_row_q + ROW_W'(1);
			row_levels_next = ~(4'b0001 << scan_row_next);
		end
	end

	// Classify a fresh press into a lock action.
	always_comb begin
		press_edge = (pressed_next != 16'd0) && (previous_q == 16'd0);
		action     = ACT_NONE;
		if (press_edge && $onehot(pressed_next)) begin
			if (pressed_next == KEY_CLEAR) begin
				action = ACT_CLEAR;
			end else if (pressed_next == KEY_BACK) begin
				action = ACT_BACK;
			end else if (pressed_next == KEY_ENTER) begin
				action = ACT_ENTER;
			end else if ((pressed_next & DIGIT_KEYS) != 16'd0) begin
				action = ACT_DIGIT;
			end
		end
	end

	always_comb begin
		push_item.row_drive = row_levels_next;
		push_item.key_word  = pressed_next;
		push_item.action    = action;
		push_item.digit     = key_to_digit(pressed_next);
	end

	// Scanner state advances once per accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q    <= '0;
			scan_row_q   <= '0;
			row_levels_q <= 4'hF;
			pressed_q    <= '0;
			previous_q   <= '0;
		end else if (push_valid) begin
			elapsed_q    <= elapsed_next;
			scan_row_q   <= scan_row_next;
			row_levels_q <= row_levels_next;
			pressed_q    <= pressed_next;
			previous_q   <= pressed_next;
		end
	end

	// At most one row is ever driven low.
	`ASSERT_AT(a_one_row_driven, clk, arst_n, $countones(~row_levels_q) <= 1,
		"more than one keypad row driven")

endmodule

// File: rtl/kscl_queue.sv
// Short queue of classified ticks between the scanner and the lock.
`include "assert_macros.svh"

module kscl_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  kscl_pkg::front_item_t   push_item,
	input  logic                    pop,
	output kscl_pkg::front_item_t   head_item,
	output kscl_pkg::queue_status_t status
);
	import kscl_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	front_item_t      entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_item    = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// The fill count stays within the depth.
	`ASSERT_AT(a_count_bound, clk, arst_n, count_q <= CNT_W'(QUEUE_DEPTH),
		"queue count beyond depth")

endmodule

// File: rtl/kscl_back.sv
// Lock back end: digit buffer, cursor, unlock flag and result register.
`include "assert_macros.svh"

module kscl_back #(
	parameter int unsigned CODE_DIGITS  = 11,
	parameter int unsigned CURSOR_LIMIT = 255
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  kscl_pkg::queue_status_t q_status,
	input  kscl_pkg::front_item_t   head_item,
	output logic                    pop,
	input  logic [43:0]             passcode,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [3:0]              row_drive,
	output logic                    unlocked,
	output logic [15:0]             key_word,
	output logic [7:0]              entry_position
);
	import kscl_pkg::*;

	localparam int unsigned IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
	localparam logic [7:0] DIGITS_C = 8'(CODE_DIGITS);
	localparam logic [7:0] LIMIT_C  = 8'(CURSOR_LIMIT);

	logic [3:0]  digits_q [CODE_DIGITS];
	logic [7:0]  cursor_q;
	logic        unlock_q;
	logic        out_valid_q;
	logic [3:0]  row_drive_q;
	logic [15:0] key_word_q;

	logic [63:0] pass_ext;
	logic        digits_match;
	logic [7:0]  cursor_dec;

	// Take the next item when the result register is free or draining.
	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	// Buffer compare against the passcode nibbles.
	always_comb begin
		pass_ext     = 64'(passcode);
		digits_match = 1'b1;
		for (int i = 0; i < CODE_DIGITS; i++) begin
			if (digits_q[i] != pass_ext[4*i +: 4]) begin
				digits_match = 1'b0;
			end
		end
		cursor_dec = cursor_q - 8'd1;
	end

	// Lock state update for the popped item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			unlock_q <= 1'b0;
			for (int i = 0; i < CODE_DIGITS; i++) begin
				digits_q[i] <= '0;
			end
		end else if (pop) begin
			case (head_item.action)
				ACT_DIGIT: begin
					if (cursor_q < DIGITS_C) begin
						digits_q[cursor_q[IDX_W-1:0]] <= head_item.digit;
					end
					if (cursor_q < LIMIT_C) begin
						cursor_q <= cursor_q + 8'd1;
					end
				end
				ACT_CLEAR: begin
					cursor_q <= '0;
					unlock_q <= 1'b0;
					for (int i = 0; i < CODE_DIGITS; i++) begin
						digits_q[i] <= '0;
					end
				end
				ACT_BACK: begin
					if (cursor_q != 8'd0 && cursor_q <= DIGITS_C) begin
						digits_q[cursor_dec[IDX_W-1:0]] <= 4'd0;
					end
					if (cursor_q != 8'd0) begin
						cursor_q <= cursor_dec;
					end
				end
				ACT_ENTER: begin
					if (digits_match && cursor_q == DIGITS_C) begin
						unlock_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			row_drive_q <= head_item.row_drive;
			key_word_q  <= head_item.key_word;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign row_drive      = row_drive_q;
	assign key_word       = key_word_q;
	assign unlocked       = unlock_q;
	assign entry_position = cursor_q;

	// The cursor saturates at its limit.
	`ASSERT_AT(a_cursor_limit, clk, arst_n, cursor_q <= LIMIT_C,
		"cursor beyond its limit")
	// A clear key leaves the lock shut with the cursor home.
	`ASSERT_AT(a_clear_locks, clk, arst_n,
		(pop && head_item.action == ACT_CLEAR) |=> (cursor_q == 8'd0 && !unlock_q),
		"clear did not lock and rewind")

endmodule

// File: rtl/keypad_scan_code_lock_top.sv
// Top level of the keypad scanner with code lock: config registers and wiring.
// An accepted tick goes through the queue, then the result register, which raises out_valid.
// Throughput: one tick per cycle; the scanner stalls only when its 4-entry queue is full.
// The lock back end retires one queued tick per cycle whenever the result register drains.
// Reset (arst_n low) idles the scan rows, clears the key map, cursor, digits and indicator,
// and loads scan_interval with 100 and the passcode with its default.
module keypad_scan_code_lock_top #(
	parameter int unsigned CODE_DIGITS  = 11,
	parameter int unsigned CURSOR_LIMIT = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  column_levels,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [3:0]  row_drive,
	output logic        unlocked,
	output logic [15:0] key_word,
	output logic [7:0]  entry_position,
	output logic        out_valid,
	input  logic        out_stall,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import kscl_pkg::*;

	logic [15:0]   scan_interval_q;
	logic [43:0]   passcode_q;
	logic          cfg_write;
	logic          push;
	logic          pop;
	front_item_t   push_item;
	front_item_t   head_item;
	queue_status_t q_status;

	// Configuration port: zero wait states, written in the access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_interval_q <= INTERVAL_RESET;
			passcode_q      <= PASSCODE_RESET;
		end else if (cfg_write) begin
			if (paddr[3] == REG_SCAN_INTERVAL) begin
				scan_interval_q <= pwdata[15:0];
			end else begin
				passcode_q <= pwdata[43:0];
			end
		end
	end

	// Register read back.
	always_comb begin
		if (paddr[3] == REG_PASSCODE) begin
			prdata = 64'(passcode_q);
		end else begin
			prdata = 64'(scan_interval_q);
		end
	end

	kscl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.column_levels (column_levels),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.scan_interval (scan_interval_q),
		.q_status      (q_status),
		.push_valid    (push),
		.push_item     (push_item)
	);

	kscl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.status    (q_status)
	);

	kscl_back #(
		.CODE_DIGITS  (CODE_DIGITS),
		.CURSOR_LIMIT (CURSOR_LIMIT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_status       (q_status),
		.head_item      (head_item),
		.pop            (pop),
		.passcode       (passcode_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.row_drive      (row_drive),
		.unlocked       (unlocked),
		.key_word       (key_word),
		.entry_position (entry_position)
	);

endmodule
